// ----- rtl/core/sxfr_pkg.sv -----
// Shared types and constants for the sync/XOR frame receiver.
// No dependencies; used by every file in rtl/core.

package sxfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd2;

  localparam logic [BYTE_W-1:0] FIRST_SYNC_RST     = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RST    = 8'hCC;
  localparam logic [BYTE_W-1:0] PAYLOAD_LENGTH_RST = 8'd8;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_SECOND = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first_sync;
    logic [BYTE_W-1:0] second_sync;
    logic [BYTE_W-1:0] payload_length;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
  } res_t;

endpackage

// ----- rtl/core/sxfr_intf.sv -----
// Valid/ready channel interfaces: received bytes, results, register writes.
// Depends on sxfr_pkg for widths.

interface sxfr_rx_if;
  logic                         valid;
  logic                         ready;
  logic [sxfr_pkg::BYTE_W-1:0]  rx_byte;
  logic                         line_error;

  modport source (output valid, output rx_byte, output line_error, input ready);
  modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

interface sxfr_res_if;
  logic                         valid;
  logic                         ready;
  logic [sxfr_pkg::KIND_W-1:0]  result_kind;
  logic [sxfr_pkg::BYTE_W-1:0]  payload_byte;
  logic [sxfr_pkg::BYTE_W-1:0]  payload_index;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_index, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input payload_index, output ready);
endinterface

interface sxfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sxfr_pkg::CFG_IDX_W-1:0] index;
  logic [sxfr_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/sync_xor_frame_receiver_top.sv -----
// Sync/XOR frame receiver top level.
// Path: an accepted byte is held in the input register, and its result in the result register until taken.
// Throughput: one byte per cycle unless the result side stalls; the input register and result register each
// hold one transaction, so a stalled result blocks input after one more byte.
// Reset (rst, synchronous): state back to hunting, counters and checksum zero,
// registers to first_sync 0xAA, second_sync 0xCC, payload_length 8.

module sync_xor_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  sxfr_rx_if.sink     rx,
  sxfr_res_if.source  result,
  sxfr_cfg_if.sink    cfg
);

  sxfr_pkg::cfg_t regs;
  sxfr_pkg::res_t res;
  logic           res_valid;
  logic           out_free;

  sxfr_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sxfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .rx        (rx),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  sxfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .result    (result)
  );

endmodule

// ----- rtl/core/sxfr_cfg_regs.sv -----
// Configuration register file: sync bytes and payload length.
// Depends on sxfr_pkg and sxfr_cfg_if.

module sxfr_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  sxfr_cfg_if.sink        cfg,
  output sxfr_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.first_sync     <= sxfr_pkg::FIRST_SYNC_RST;
      regs.second_sync    <= sxfr_pkg::SECOND_SYNC_RST;
      regs.payload_length <= sxfr_pkg::PAYLOAD_LENGTH_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        sxfr_pkg::CFG_FIRST_SYNC:     regs.first_sync     <= cfg.data;
        sxfr_pkg::CFG_SECOND_SYNC:    regs.second_sync    <= cfg.data;
        sxfr_pkg::CFG_PAYLOAD_LENGTH: regs.payload_length <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sxfr_core.sv -----
// Input register and frame state machine: sync hunt, payload indexing,
// running XOR checksum and verdict. Depends on sxfr_pkg and sxfr_rx_if.

module sxfr_core (
  input  logic            clk,
  input  logic            rst,
  input  sxfr_pkg::cfg_t  regs,
  sxfr_rx_if.sink         rx,
  input  logic            out_free,
  output logic            res_valid,
  output sxfr_pkg::res_t  res
);

  logic                        s1_valid;
  logic [sxfr_pkg::BYTE_W-1:0] s1_byte;
  logic                        s1_err;
  logic                        advance;

  sxfr_pkg::phase_t            phase, phase_next;
  logic [sxfr_pkg::BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [sxfr_pkg::BYTE_W-1:0] running_xor, running_xor_next;

  assign advance  = s1_valid && out_free;
  assign rx.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
      s1_err  <= rx.line_error;
    end
  end

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    running_xor_next = running_xor;
    res_valid        = 1'b0;
    res.result_kind  = sxfr_pkg::KIND_PAYLOAD;
    res.payload_byte = s1_byte;
    res.payload_index = '0;
    if (advance && !s1_err) begin
      case (phase)
        sxfr_pkg::PH_SECOND: begin
          if (s1_byte == regs.second_sync) begin
            bytes_left_next  = regs.payload_length;
            running_xor_next = running_xor ^ s1_byte;
            phase_next       = sxfr_pkg::PH_BODY;
          end else begin
            phase_next = sxfr_pkg::PH_HUNT;
          end
        end
        sxfr_pkg::PH_BODY: begin
          res_valid = 1'b1;
          if (bytes_left != '0) begin
            res.payload_index = regs.payload_length - bytes_left;
            running_xor_next  = running_xor ^ s1_byte;
            bytes_left_next   = bytes_left - 1'b1;
          end else begin
            res.result_kind = (s1_byte == running_xor) ? sxfr_pkg::KIND_GOOD
                                                       : sxfr_pkg::KIND_BAD;
            phase_next      = sxfr_pkg::PH_HUNT;
          end
        end
        default: begin
          if (s1_byte == regs.first_sync) begin
            running_xor_next = s1_byte;
            phase_next       = sxfr_pkg::PH_SECOND;
          end else begin
            phase_next = sxfr_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sxfr_pkg::PH_HUNT;
      bytes_left  <= '0;
      running_xor <= '0;
    end else begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_xor <= running_xor_next;
    end
  end

endmodule

// ----- rtl/core/sxfr_out_reg.sv -----
// Result register: holds one result until the downstream transaction completes.
// Depends on sxfr_pkg and sxfr_res_if.

module sxfr_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  input  sxfr_pkg::res_t  res,
  output logic            out_free,
  sxfr_res_if.source      result
);

  sxfr_pkg::res_t held;

  assign out_free             = !result.valid || result.ready;
  assign result.result_kind   = held.result_kind;
  assign result.payload_byte  = held.payload_byte;
  assign result.payload_index = held.payload_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= res_valid;
    end
    if (out_free && res_valid) begin
      held <= res;
    end
  end

endmodule

// ----- tb/sync_xor_frame_receiver_top_tb.sv -----
`timescale 1ns / 100ps

// Testbench for sync_xor_frame_receiver_top: directed frames, then random byte streams
// with line errors and register writes between phases, throttled on both channels.
// Depends on sxfr_pkg, the sxfr_*_if interfaces and the RTL top level.

module sync_xor_frame_receiver_top_tb;
  import sxfr_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int LATENCY      = 2;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASES       = 10;
  localparam int REPORT_MAX   = 10;

  typedef enum int {RCV_ALWAYS, RCV_RANDOM, RCV_PERIODIC} rcv_mode_t;

  logic clk;
  logic rst;

  sxfr_rx_if  rx_ch ();
  sxfr_res_if res_ch ();
  sxfr_cfg_if cfg_ch ();

  sync_xor_frame_receiver_top u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  cfg_t       regs;
  phase_t     frame_phase;
  logic [7:0] bytes_left;
  logic [7:0] frame_xor;
  res_t       pending_results[$];

  int unsigned cycle_cnt    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned errs_sent    = 0;
  int unsigned results_seen = 0;
  int unsigned good_seen    = 0;
  int unsigned bad_seen     = 0;
  int unsigned mismatches   = 0;

  int unsigned burst_max  = 1;
  int unsigned gap_max    = 0;
  int unsigned burst_left = 0;
  rcv_mode_t   rcv_mode   = RCV_ALWAYS;
  int unsigned rcv_pct    = 100;
  int unsigned rcv_on     = 1;
  int unsigned rcv_off    = 1;
  int unsigned hold_req   = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  // Frame parser: returns 1 when the byte yields a result transaction.
  function automatic bit parse_byte(input logic [7:0] data, input logic err, output res_t r);
    bit hit;
    hit = 1'b0;
    r = '0;
    if (!err) begin
      case (frame_phase)
        PH_SECOND: begin
          if (data == regs.second_sync) begin
            bytes_left = regs.payload_length;
            frame_xor ^= data;
            frame_phase = PH_BODY;
          end else begin
            frame_phase = PH_HUNT;
          end
        end
        PH_BODY: begin
          hit = 1'b1;
          r.payload_byte = data;
          if (bytes_left != 8'd0) begin
            r.result_kind = KIND_PAYLOAD;
            r.payload_index = regs.payload_length - bytes_left;
            frame_xor ^= data;
            bytes_left--;
          end else begin
            r.result_kind = (data == frame_xor) ? KIND_GOOD : KIND_BAD;
            r.payload_index = '0;
            frame_phase = PH_HUNT;
          end
        end
        default: begin
          if (data == regs.first_sync) begin
            frame_xor = data;
            frame_phase = PH_SECOND;
          end else begin
            frame_phase = PH_HUNT;
          end
        end
      endcase
    end
    return hit;
  endfunction

  function automatic void report(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display({"%s at cycle %0d: expected kind %0d byte %02h index %0d, ",
                "got kind %0d byte %02h index %0d"},
               what, cycle_cnt, want.result_kind, want.payload_byte, want.payload_index,
               got.result_kind, got.payload_byte, got.payload_index);
  endfunction

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.result_kind, res_ch.payload_byte, res_ch.payload_index};
      results_seen++;
      if (got.result_kind == KIND_GOOD) good_seen++;
      if (got.result_kind == KIND_BAD) bad_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind || got.payload_byte !== want.payload_byte ||
            got.payload_index !== want.payload_index)
          report("mismatch", want, got);
      end
    end
  end

  // Result-side throttle; a hold request keeps ready low until its hold count runs out.
  initial begin : result_sink
    int unsigned hold_cnt;
    int unsigned tick;
    hold_cnt = 0;
    tick = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      tick++;
      if (hold_cnt != 0) begin
        hold_cnt--;
        res_ch.ready <= 1'b0;
      end else begin
        case (rcv_mode)
          RCV_ALWAYS: res_ch.ready <= 1'b1;
          RCV_RANDOM: res_ch.ready <= ($urandom_range(99) < rcv_pct);
          default:    res_ch.ready <= ((tick % (rcv_on + rcv_off)) < rcv_on);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the transaction.
  task automatic send_byte(input logic [7:0] data, input logic err = 1'b0);
    res_t r;
    if (gap_max != 0 && burst_left == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(negedge clk);
      burst_left = $urandom_range(burst_max, 1);
    end
    rx_ch.valid      <= 1'b1;
    rx_ch.rx_byte    <= data;
    rx_ch.line_error <= err;
    do @(posedge clk); while (!rx_ch.ready);
    if (parse_byte(data, err, r)) pending_results.push_back(r);
    if (err) errs_sent++;
    else bytes_sent++;
    if (burst_left != 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic rx_idle();
    rx_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    rx_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_FIRST_SYNC:     regs.first_sync = value;
      CFG_SECOND_SYNC:    regs.second_sync = value;
      CFG_PAYLOAD_LENGTH: regs.payload_length = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_frame(input int n_payload, input bit good_sum, input int err_pct);
    logic [7:0] sum;
    logic [7:0] b;
    sum = regs.first_sync ^ regs.second_sync;
    send_byte(regs.first_sync);
    send_byte(regs.second_sync);
    for (int i = 0; i < n_payload; i++) begin
      if ($urandom_range(99) < err_pct) send_byte(8'($urandom_range(255)), 1'b1);
      b = 8'($urandom_range(255));
      sum ^= b;
      send_byte(b);
    end
    send_byte(good_sum ? sum : 8'($urandom_range(255)));
  endtask

  task automatic test_default_frame();
    logic [7:0] body [8];
    logic [7:0] sum;
    body = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hCC};
    sum = regs.first_sync ^ regs.second_sync;
    send_byte(regs.first_sync);
    send_byte(regs.second_sync);
    foreach (body[i]) begin
      if (i == 4) send_byte(8'hAA, 1'b1);  // dropped, must not disturb the frame
      sum ^= body[i];
      send_byte(body[i]);
    end
    send_byte(sum);
    wait_drained();
  endtask

  // A bad second byte sends the parser back to hunting without a resync check.
  task automatic test_wrong_second_sync();
    send_byte(regs.first_sync);
    send_byte(regs.first_sync);
    send_byte(regs.second_sync);
    send_byte(8'h00);
    wait_drained();
  endtask

  task automatic test_empty_payload();
    write_reg(CFG_PAYLOAD_LENGTH, 8'd0);
    send_byte(regs.first_sync);
    send_byte(regs.second_sync);
    send_byte(regs.first_sync ^ regs.second_sync);
    send_byte(regs.first_sync);
    send_byte(regs.second_sync);
    send_byte(~(regs.first_sync ^ regs.second_sync));
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_PAYLOAD_LENGTH, 8'd16);
    gap_max = 0;
    rcv_mode = RCV_ALWAYS;
    hold_req = 150;
    send_frame(16, 1'b1, 0);
    wait_drained();
    rcv_mode = RCV_PERIODIC;
    rcv_on = 1;
    rcv_off = 3;
    send_frame(16, 1'b0, 10);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] len;
    int unsigned target;
    int unsigned r;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          s1 = FIRST_SYNC_RST;
          s2 = SECOND_SYNC_RST;
          len = PAYLOAD_LENGTH_RST;
        end
        1: begin
          s1 = 8'h00;
          s2 = 8'hFF;
          len = 8'd0;
        end
        2: begin
          s1 = 8'hFF;
          s2 = 8'h00;
          len = 8'd255;
        end
        3: begin
          s1 = 8'($urandom_range(255));
          s2 = s1;
          len = 8'($urandom_range(6));
        end
        default: begin
          s1 = 8'($urandom_range(255));
          s2 = 8'($urandom_range(255));
          len = 8'($urandom_range(12, 1));
        end
      endcase
      write_reg(CFG_FIRST_SYNC, s1);
      write_reg(CFG_SECOND_SYNC, s2);
      write_reg(CFG_PAYLOAD_LENGTH, len);
      if (ph == 0) begin
        gap_max = 0;
        rcv_mode = RCV_ALWAYS;
      end else begin
        burst_max = $urandom_range(20, 1);
        gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
        rcv_mode = rcv_mode_t'($urandom_range(2));
        rcv_pct = $urandom_range(90, 30);
        rcv_on = $urandom_range(8, 1);
        rcv_off = $urandom_range(8, 1);
      end
      burst_left = 0;
      target = bytes_sent + RANDOM_ITEMS / PHASES;
      while (bytes_sent < target) begin
        r = $urandom_range(99);
        if (r < 70) begin
          send_frame(len, $urandom_range(99) < 75, 5);
        end else if (r < 80) begin
          send_byte(s1);
          send_byte(($urandom_range(2) == 0) ? s1 : 8'($urandom_range(255)));
        end else if (r < 90) begin
          send_byte(s1);
          send_byte(s2);
          repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(5, 1))
            send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
      end
      // leave a frame open so the next register writes land mid-frame; with payload length zero the last byte closes it
      if (ph % 2 == 1) begin
        send_byte(s1);
        send_byte(s2);
        send_byte(8'($urandom_range(255)));
      end
    end
    wait_drained();
  endtask

  initial begin : main
    int unsigned waited;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    rx_ch.line_error = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    regs = {FIRST_SYNC_RST, SECOND_SYNC_RST, PAYLOAD_LENGTH_RST};
    frame_phase = PH_HUNT;
    bytes_left = '0;
    frame_xor = '0;
    waited = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_frame();
    test_wrong_second_sync();
    test_empty_payload();
    test_backpressure();
    test_random_traffic();

    while (pending_results.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY + 8) @(negedge clk);
    foreach (pending_results[i]) report("missing result", pending_results[i], '0);

    $display("sent %0d bytes plus %0d with line errors over %0d register phases",
             bytes_sent, errs_sent, PHASES);
    $display("checked %0d results (%0d good frames, %0d bad frames), %0d mismatches",
             results_seen, good_seen, bad_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
